/* rtl/tofrp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tofrp_pkg;

   // Field widths of the depth sample and of the pixel position.
   localparam int DEPTH_W = 16;
   localparam int POS_W   = 10;

   // Configuration register widths.
   localparam int CTR_W      = 14;
   localparam int INV_W      = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Internal datapath widths.
   localparam int MAG_W  = 14;
   localparam int TAN_W  = 26;
   localparam int TSQ_W  = 2 * TAN_W;
   localparam int SUM_W  = 56;
   localparam int ROOT_W = SUM_W / 2;
   localparam int SREM_W = ROOT_W + 3;
   localparam int DREM_W = ROOT_W + 1;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RANGE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_FOCAL_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_FOCAL_Y = 3'd5;

   localparam logic [DEPTH_W-1:0] MAX_RANGE_RESET = 16'd16000;

   // Parameter defaults.
   localparam int MAX_COLUMNS_DEF      = 1024;
   localparam int MAX_ROWS_DEF         = 1024;
   localparam int FACTOR_FRAC_BITS_DEF = 16;

endpackage

`default_nettype wire

/* rtl/tof_ray_to_planar_depth_unit.sv */
// Throughput: one item per cycle; busy is never raised, the pipeline has no stall.
// The depth is set by the square root (one root bit per stage, 28 stages) and the
// reciprocal divider (one quotient bit per stage, FACTOR_FRAC_BITS + 1 stages).
// Reset clears all valid bits and loads the register defaults; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module tof_ray_to_planar_depth_unit
   import tofrp_pkg::*;
#(
   parameter int MAX_COLUMNS      = MAX_COLUMNS_DEF,
   parameter int MAX_ROWS         = MAX_ROWS_DEF,
   parameter int FACTOR_FRAC_BITS = FACTOR_FRAC_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [DEPTH_W-1:0]    req_depth_in,
   input  wire logic [POS_W-1:0]      req_column,
   input  wire logic [POS_W-1:0]      req_row,
   input  wire logic                  req_last_in,
   output logic                       rsp_valid,
   output logic [DEPTH_W-1:0]         rsp_depth_out,
   output logic                       rsp_last_out,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int FW     = FACTOR_FRAC_BITS + 1;
   localparam int NSB    = 4 + ROOT_W + FW;
   localparam int PROD_W = DEPTH_W + FW;
   localparam logic [FW-1:0] FACTOR_ONE = FW'(1) << FACTOR_FRAC_BITS;

   // Configuration registers.
   logic                enable_ff;
   logic [DEPTH_W-1:0]  max_range_ff;
   logic [CTR_W-1:0]    center_x_ff;
   logic [CTR_W-1:0]    center_y_ff;
   logic [INV_W-1:0]    inv_x_ff;
   logic [INV_W-1:0]    inv_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         max_range_ff <= MAX_RANGE_RESET;
         center_x_ff  <= '0;
         center_y_ff  <= '0;
         inv_x_ff     <= '0;
         inv_y_ff     <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ENABLE:      enable_ff    <= csr_write_data[0];
            CSR_MAX_RANGE:   max_range_ff <= csr_write_data[DEPTH_W-1:0];
            CSR_CENTER_X:    center_x_ff  <= csr_write_data[CTR_W-1:0];
            CSR_CENTER_Y:    center_y_ff  <= csr_write_data[CTR_W-1:0];
            CSR_INV_FOCAL_X: inv_x_ff     <= csr_write_data[INV_W-1:0];
            CSR_INV_FOCAL_Y: inv_y_ff     <= csr_write_data[INV_W-1:0];
            default: ;
         endcase
      end
   end

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Sideband that travels with each item.
   logic               sb_valid_ff  [1:NSB+1];
   logic [DEPTH_W-1:0] sb_depth_ff  [1:NSB+1];
   logic               sb_last_ff   [1:NSB+1];
   logic               sb_bypass_ff [1:NSB+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 1; p <= NSB + 1; p++) sb_valid_ff[p] <= 1'b0;
      end else begin
         sb_valid_ff[1] <= accept;
         for (int p = 2; p <= NSB + 1; p++) sb_valid_ff[p] <= sb_valid_ff[p-1];
      end
   end

   always_ff @(posedge clock) begin
      sb_depth_ff[1]  <= req_depth_in;
      sb_last_ff[1]   <= req_last_in;
      sb_bypass_ff[1] <= (inv_x_ff == '0) || (inv_y_ff == '0);
      for (int p = 2; p <= NSB + 1; p++) begin
         sb_depth_ff[p]  <= sb_depth_ff[p-1];
         sb_last_ff[p]   <= sb_last_ff[p-1];
         sb_bypass_ff[p] <= sb_bypass_ff[p-1];
      end
   end

   // Stage 1: clamp the pixel position and take the offset from the center.
   logic [POS_W-1:0] col_in, row_in;
   logic [CTR_W-1:0] pcol_in, prow_in;
   logic [MAG_W-1:0] mag_x_in, mag_y_in;
   logic [MAG_W-1:0] mag_x_ff, mag_y_ff;

   always_comb begin
      col_in = req_column;
      row_in = req_row;
      if (int'(req_column) >= MAX_COLUMNS) col_in = POS_W'(MAX_COLUMNS - 1);
      if (int'(req_row) >= MAX_ROWS)       row_in = POS_W'(MAX_ROWS - 1);
      pcol_in  = {col_in, 4'b0000};
      prow_in  = {row_in, 4'b0000};
      mag_x_in = (center_x_ff >= pcol_in) ? (center_x_ff - pcol_in) : (pcol_in - center_x_ff);
      mag_y_in = (center_y_ff >= prow_in) ? (center_y_ff - prow_in) : (prow_in - center_y_ff);
   end

   always_ff @(posedge clock) begin
      mag_x_ff <= mag_x_in;
      mag_y_ff <= mag_y_in;
   end

   // Stage 2: tangents in Q16.
   logic [MAG_W+INV_W-1:0] prod_x_in, prod_y_in;
   logic [TAN_W-1:0]       tan_x_ff, tan_y_ff;

   assign prod_x_in = (MAG_W+INV_W)'(mag_x_ff) * (MAG_W+INV_W)'(inv_x_ff);
   assign prod_y_in = (MAG_W+INV_W)'(mag_y_ff) * (MAG_W+INV_W)'(inv_y_ff);

   always_ff @(posedge clock) begin
      tan_x_ff <= prod_x_in[MAG_W+INV_W-1:12];
      tan_y_ff <= prod_y_in[MAG_W+INV_W-1:12];
   end

   // Stage 3: squares of the tangents.
   logic [TSQ_W-1:0] tsq_x_ff, tsq_y_ff;

   always_ff @(posedge clock) begin
      tsq_x_ff <= TSQ_W'(tan_x_ff) * TSQ_W'(tan_x_ff);
      tsq_y_ff <= TSQ_W'(tan_y_ff) * TSQ_W'(tan_y_ff);
   end

   // Stage 4: radicand 1 + tx^2 + ty^2 at scale 2^32, seeds the root.
   logic [SUM_W-1:0]  sq_s_ff    [0:ROOT_W];
   logic [SREM_W-1:0] sq_rem_ff  [0:ROOT_W];
   logic [ROOT_W-1:0] sq_root_ff [0:ROOT_W];

   always_ff @(posedge clock) begin
      sq_s_ff[0]    <= (SUM_W'(1) << 32) + SUM_W'(tsq_x_ff) + SUM_W'(tsq_y_ff);
      sq_rem_ff[0]  <= '0;
      sq_root_ff[0] <= '0;
   end

   // Square root: one root bit per stage, restoring remainder method.
   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      logic [SREM_W-1:0] trial_in, test_in;
      assign trial_in = {sq_rem_ff[k][SREM_W-3:0], sq_s_ff[k][SUM_W-1-2*k -: 2]};
      assign test_in  = {1'b0, sq_root_ff[k], 2'b01};

      always_ff @(posedge clock) begin
         sq_s_ff[k+1] <= sq_s_ff[k];
         if (trial_in >= test_in) begin
            sq_rem_ff[k+1]  <= trial_in - test_in;
            sq_root_ff[k+1] <= {sq_root_ff[k][ROOT_W-2:0], 1'b1};
         end else begin
            sq_rem_ff[k+1]  <= trial_in;
            sq_root_ff[k+1] <= {sq_root_ff[k][ROOT_W-2:0], 1'b0};
         end
      end
   end

   // Reciprocal 2^(F+16) / root: one quotient bit per stage.
   logic [DREM_W-1:0] dv_rem_ff  [1:FW];
   logic [ROOT_W-1:0] dv_div_ff  [1:FW];
   logic [FW-1:0]     dv_q_ff    [1:FW];

   for (genvar j = 0; j < FW; j++) begin : g_div
      logic [DREM_W-1:0] rem_cur;
      logic [ROOT_W-1:0] div_cur;
      logic [FW-1:0]     q_cur;
      logic [DREM_W-1:0] shifted_in;

      // The first step starts from the dividend shifted down by the quotient width.
      if (j == 0) begin : g_seed
         assign rem_cur = DREM_W'(1) << 15;
         assign div_cur = sq_root_ff[ROOT_W];
         assign q_cur   = '0;
      end else begin : g_link
         assign rem_cur = dv_rem_ff[j];
         assign div_cur = dv_div_ff[j];
         assign q_cur   = dv_q_ff[j];
      end

      assign shifted_in = {rem_cur[DREM_W-2:0], 1'b0};

      always_ff @(posedge clock) begin
         dv_div_ff[j+1] <= div_cur;
         if (shifted_in >= {1'b0, div_cur}) begin
            dv_rem_ff[j+1] <= shifted_in - {1'b0, div_cur};
            dv_q_ff[j+1]   <= {q_cur[FW-2:0], 1'b1};
         end else begin
            dv_rem_ff[j+1] <= shifted_in;
            dv_q_ff[j+1]   <= {q_cur[FW-2:0], 1'b0};
         end
      end
   end

   // Scale the sample by the factor.
   logic [FW-1:0]     factor_in;
   logic [PROD_W-1:0] scaled_ff;

   assign factor_in = sb_bypass_ff[NSB] ? FACTOR_ONE : dv_q_ff[FW];

   always_ff @(posedge clock) begin
      scaled_ff <= PROD_W'(sb_depth_ff[NSB]) * PROD_W'(factor_in);
   end

   // Output register: pass-through, sample at range, and clamp.
   logic [DEPTH_W:0]   shifted_prod_in;
   logic [DEPTH_W:0]   result_wide_in;
   logic [DEPTH_W-1:0] result_in;
   logic               rsp_valid_ff;
   logic [DEPTH_W-1:0] rsp_depth_ff;
   logic               rsp_last_ff;

   always_comb begin
      shifted_prod_in = (DEPTH_W+1)'(scaled_ff >> FACTOR_FRAC_BITS);
      if (sb_depth_ff[NSB+1] == max_range_ff) result_wide_in = {1'b0, sb_depth_ff[NSB+1]};
      else                                    result_wide_in = shifted_prod_in;
      if (!enable_ff)                                  result_in = sb_depth_ff[NSB+1];
      else if (result_wide_in > {1'b0, max_range_ff})  result_in = max_range_ff;
      else                                             result_in = result_wide_in[DEPTH_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sb_valid_ff[NSB+1];
      end
      rsp_depth_ff <= result_in;
      rsp_last_ff  <= sb_last_ff[NSB+1];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_depth_out = rsp_depth_ff;
   assign rsp_last_out  = rsp_last_ff;

   // The radicand is at least 2^32, so the root is at least 2^16.
   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      sb_valid_ff[4+ROOT_W] |-> (sq_root_ff[ROOT_W] >= (ROOT_W'(1) << 16)))
      else $error("square root below one");

   // The factor never exceeds one.
   a_factor_max: assert property (@(posedge clock) disable iff (reset)
      sb_valid_ff[NSB] |-> (dv_q_ff[FW] <= FACTOR_ONE))
      else $error("correction factor above one");

   // An enabled result never exceeds the range.
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && enable_ff) |-> (rsp_depth_out <= max_range_ff))
      else $error("result above range");

   // Reset empties the pipeline.
   a_reset_flush: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("item delivered right after reset");

endmodule

`default_nettype wire
